@@ hw/rtl/sfcc_pkg.sv @@
// Shared types, constants and the byte-wide CRC-16/MODBUS step.
// No dependencies; used by every module of sensor_frame_crc_check.
package sfcc_pkg;

  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPolyRefl = 16'hA001;
  localparam logic [2:0]  CrcSpan     = 3'd6;   // bytes 0..5 are covered by the CRC
  localparam logic [2:0]  PosHumHi    = 3'd2;
  localparam logic [2:0]  PosHumLo    = 3'd3;
  localparam logic [2:0]  PosTempHi   = 3'd4;
  localparam logic [2:0]  PosTempLo   = 3'd5;
  localparam logic [2:0]  PosCrcLo    = 3'd6;
  localparam logic [2:0]  PosLast     = 3'd7;

  // One result word as it travels to the output register
  typedef struct packed {
    logic        valid;
    logic [15:0] humidity_word;
    logic [15:0] temperature_word;
    logic        crc_ok;
  } sfcc_res_t;

  // Reflected CRC update over one byte, eight bit steps unrolled
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPolyRefl;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/sfcc_frame_track.sv @@
// Frame tracker: byte position, running CRC and the held sensor words.
// Depends on sfcc_pkg.
module sfcc_frame_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_start_i,
  output sfcc_pkg::sfcc_res_t res_o
);
  import sfcc_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [2:0]  pos_q, pos_d;
  logic [15:0] hum_q, hum_d;
  logic [15:0] temp_q, temp_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] crc_cur;
  logic [2:0]  pos_cur;

  // frame start restarts the count and the CRC before this byte is used
  assign pos_cur = frame_start_i ? 3'd0 : pos_q;
  assign crc_cur = frame_start_i ? CrcInit : crc_q;

  always_comb begin
    crc_d    = crc_cur;
    pos_d    = pos_cur + 3'd1;
    hum_d    = hum_q;
    temp_d   = temp_q;
    crc_lo_d = crc_lo_q;
    if (pos_cur < CrcSpan) begin
      crc_d = crc_byte(crc_cur, data_byte_i);
    end
    case (pos_cur)
      PosHumHi:  hum_d[15:8]  = data_byte_i;
      PosHumLo:  hum_d[7:0]   = data_byte_i;
      PosTempHi: temp_d[15:8] = data_byte_i;
      PosTempLo: temp_d[7:0]  = data_byte_i;
      PosCrcLo:  crc_lo_d     = data_byte_i;
      default: ;
    endcase
    if (pos_cur == PosLast) begin
      pos_d = 3'd0;
      crc_d = CrcInit;
    end
  end

  // result uses the held words; the CRC is already final after byte 5
  assign res_o.valid            = take_i && (pos_cur == PosLast);
  assign res_o.humidity_word    = hum_q;
  assign res_o.temperature_word = temp_q;
  assign res_o.crc_ok           = (crc_cur == {data_byte_i, crc_lo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CrcInit;
      pos_q    <= 3'd0;
      hum_q    <= 16'h0000;
      temp_q   <= 16'h0000;
      crc_lo_q <= 8'h00;
    end else if (take_i) begin
      crc_q    <= crc_d;
      pos_q    <= pos_d;
      hum_q    <= hum_d;
      temp_q   <= temp_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

@@ hw/rtl/sfcc_out_reg.sv @@
// Output register for result words, valid/stall towards the receiver.
// Depends on sfcc_pkg.
module sfcc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfcc_pkg::sfcc_res_t res_i,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         humidity_word_o,
  output logic [15:0]         temperature_word_o,
  output logic                crc_ok_o
);
  import sfcc_pkg::*;

  logic        valid_q;
  logic [15:0] hum_q;
  logic [15:0] temp_q;
  logic        ok_q;

  // a word still waiting under stall blocks the next load
  assign busy_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!busy_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_o && res_i.valid) begin
      hum_q  <= res_i.humidity_word;
      temp_q <= res_i.temperature_word;
      ok_q   <= res_i.crc_ok;
    end
  end

  assign out_valid_o        = valid_q;
  assign humidity_word_o    = hum_q;
  assign temperature_word_o = temp_q;
  assign crc_ok_o           = ok_q;

endmodule

@@ hw/rtl/sensor_frame_crc_check.sv @@
// Top level of the sensor frame CRC checker.
// Depends on sfcc_pkg, sfcc_frame_track and sfcc_out_reg.
//
// Usage:
//   Input channel: one frame byte per word (data_byte_i, frame_start_i),
//   taken when in_valid_i is high and in_stall_o is low. An eight-byte
//   frame is bytes 0..7; frame_start_i marks byte 0 and drops any partial
//   frame. Frames may also follow one another without frame_start_i.
//   Bytes 0..5 run through CRC-16/MODBUS (init FFFF, reflected A001);
//   bytes 2-3 are the humidity word and 4-5 the temperature word, both
//   high byte first; bytes 6-7 carry the received CRC, low byte first.
//   Output channel: one word per frame, out_valid_o with humidity,
//   temperature and crc_ok (computed CRC equals received CRC).
//   Output register: the result appears there the cycle after byte 7 is taken.
//   Throughput: one byte per cycle while in_stall_o is low; the CRC update of a
//   byte is an unrolled eight-step chain between the state registers.
//   Stall: while a result sits in the output register with out_stall_i
//   high, in_stall_o is raised and no byte is taken; the held result
//   does not change.
//   Reset: CRC to FFFF, byte count and held words to zero, output empty.
module sensor_frame_crc_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] humidity_word_o,
  output logic [15:0] temperature_word_o,
  output logic        crc_ok_o
);
  import sfcc_pkg::*;

  sfcc_res_t res;
  logic      busy;
  logic      take;

  // byte taken this cycle
  assign take       = in_valid_i && !busy;
  assign in_stall_o = busy;

  sfcc_frame_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .res_o         (res)
  );

  sfcc_out_reg u_out (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .res_i              (res),
    .busy_o             (busy),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .humidity_word_o    (humidity_word_o),
    .temperature_word_o (temperature_word_o),
    .crc_ok_o           (crc_ok_o)
  );

endmodule
